>>> rtl/ctc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the command token classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int MAX_KEYWORDS  = 6;
  localparam int KEYWORD_CHARS = 8;
  localparam int KW_WIDTH      = 8 * KEYWORD_CHARS;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

  localparam logic [2:0] REG_KW_COUNT = 3'd6;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_HEX     = 2'd1,
    KIND_NONE    = 2'd2,
    KIND_EOL     = 2'd3
  } kind_e;

  // One closed token and/or end of line, front to back.
  typedef struct packed {
    logic       tok;
    logic       eol;
    kind_e      kind;
    logic [2:0] kw_idx;
    logic [7:0] hex;
  } ctc_entry_t;

endpackage
`default_nettype wire

>>> rtl/ctc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_front
// Collects token bytes, holds the keyword registers and classifies each token
// as it closes on a space or a zero byte.
// ----------------------------------------------------------------------------
module ctc_front
  import ctc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [KW_WIDTH-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  input  wire logic [7:0]          in_char_i,
  input  wire logic                q_ready_i,
  output      logic                push_o,
  output      ctc_entry_t          entry_o
);

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [3:0] LEN_SAT    = 4'(KEYWORD_CHARS + 1);
  localparam logic [3:0] LEN_FULL   = 4'(KEYWORD_CHARS);

  logic [KW_WIDTH-1:0] kw_q [MAX_KEYWORDS];
  logic [2:0]          kw_cnt_q;
  logic [7:0]          tok_q [KEYWORD_CHARS];
  logic [3:0]          len_q, len_d;

  logic       accept;
  logic       is_zero, is_space;
  logic [2:0] kw_n;
  logic [MAX_KEYWORDS-1:0] kw_hit;
  logic       any_hit;
  logic [2:0] hit_idx;
  logic [4:0] hex_hi, hex_lo;
  logic       hex_ok;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    hex_digit = 5'd0;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
      hex_digit = {1'b1, v[3:0]};
    end else if (c >= "A" && c <= "F") begin
      v = c - 8'd55;
      hex_digit = {1'b1, v[3:0]};
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'd87;
      hex_digit = {1'b1, v[3:0]};
    end
  endfunction

  assign accept   = in_valid_i && q_ready_i;
  assign is_zero  = (in_char_i == 8'd0);
  assign is_space = (in_char_i == CHAR_SPACE);
  assign kw_n     = (kw_cnt_q > 3'(MAX_KEYWORDS)) ? 3'(MAX_KEYWORDS) : kw_cnt_q;

  // keyword compare, all keywords in parallel
  always_comb begin
    logic ok;
    logic [7:0] kb;
    for (int j = 0; j < MAX_KEYWORDS; j++) begin
      ok = (len_q != 4'd0) && (len_q <= LEN_FULL) && (3'(j) < kw_n);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        kb = kw_q[j][8*i +: 8];
        if (4'(i) < len_q) begin
          if (to_lower(tok_q[i]) != kb) ok = 1'b0;
        end else if (4'(i) == len_q) begin
          if (kb != 8'd0) ok = 1'b0;
        end
      end
      kw_hit[j] = ok;
    end
  end

  always_comb begin
    any_hit = 1'b0;
    hit_idx = 3'd0;
    for (int j = MAX_KEYWORDS - 1; j >= 0; j--) begin
      if (kw_hit[j]) begin
        any_hit = 1'b1;
        hit_idx = 3'(j);
      end
    end
  end

  assign hex_hi = hex_digit(tok_q[2]);
  assign hex_lo = hex_digit(tok_q[3]);
  assign hex_ok = (len_q == 4'd4) && (tok_q[0] == "0") && (tok_q[1] == "x") &&
                  hex_hi[4] && hex_lo[4];

  always_comb begin
    entry_o.tok    = (len_q != 4'd0);
    entry_o.eol    = is_zero;
    entry_o.kind   = KIND_NONE;
    entry_o.kw_idx = 3'd0;
    entry_o.hex    = 8'd0;
    if (any_hit) begin
      entry_o.kind   = KIND_KEYWORD;
      entry_o.kw_idx = hit_idx;
    end else if (hex_ok) begin
      entry_o.kind = KIND_HEX;
      entry_o.hex  = {hex_hi[3:0], hex_lo[3:0]};
    end
  end

  assign push_o = accept && (is_zero || (is_space && len_q != 4'd0));

  always_comb begin
    len_d = len_q;
    if (accept) begin
      if (is_zero || is_space) begin
        len_d = 4'd0;
      end else if (len_q < LEN_SAT) begin
        len_d = len_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= 4'd0;
      kw_cnt_q <= 3'd0;
      for (int j = 0; j < MAX_KEYWORDS; j++) kw_q[j] <= '0;
    end else begin
      len_q <= len_d;
      if (cfg_we_i) begin
        for (int j = 0; j < MAX_KEYWORDS; j++) begin
          if (cfg_idx_i == 3'(j)) kw_q[j] <= cfg_data_i;
        end
        if (cfg_idx_i == REG_KW_COUNT) kw_cnt_q <= cfg_data_i[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_zero && !is_space && len_q < LEN_FULL) begin
      tok_q[len_q[2:0]] <= in_char_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_fifo
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module ctc_fifo
  import ctc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ctc_entry_t push_data_i,
  input  wire logic       pop_i,
  output ctc_entry_t      pop_data_o,
  output      logic       full_o,
  output      logic       empty_o
);

  ctc_entry_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

>>> rtl/ctc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_back
// Turns queue entries into result words: the token result, then end of line.
// ----------------------------------------------------------------------------
module ctc_back
  import ctc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctc_entry_t entry_i,
  input  wire logic       empty_i,
  output      logic       pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      kind_e      out_kind_o,
  output      logic [2:0] out_idx_o,
  output      logic [7:0] out_hex_o,
  output      logic       out_last_o
);

  logic       valid_q;
  logic       phase_q, phase_d;   // token already sent, EOL pending
  kind_e      kind_q, kind_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] hex_q, hex_d;
  logic       last_q, last_d;
  logic       load, emit;

  assign load = !valid_q || out_ready_i;
  assign emit = load && !empty_i;

  always_comb begin
    phase_d = phase_q;
    pop_o   = 1'b0;
    kind_d  = KIND_EOL;
    idx_d   = 3'd0;
    hex_d   = 8'd0;
    last_d  = 1'b1;
    if (entry_i.tok && !phase_q) begin
      kind_d = entry_i.kind;
      idx_d  = entry_i.kw_idx;
      hex_d  = entry_i.hex;
      last_d = 1'b0;
      if (emit) begin
        if (entry_i.eol) phase_d = 1'b1;
        else pop_o = 1'b1;
      end
    end else if (emit) begin
      pop_o   = 1'b1;
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
      hex_q  <= hex_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_idx_o   = idx_q;
  assign out_hex_o   = hex_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

>>> rtl/command_token_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_token_classifier
// Splits a command line into space-separated tokens and sorts each token.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while the four-word queue between the
// tokenizer and the result stage has room. A closing space or zero byte is
// classified in the cycle it is accepted, queued, and then loaded into the
// output register. The result stage sends one word per cycle while the output
// is ready, so a zero byte that closes a token yields two words (token result,
// then end of line with tlast set); input stalls only when the queue is full.
module command_token_classifier
  import ctc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [KW_WIDTH-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] char_in
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [15:0]         m_axis_tdata,   // [2:0] keyword_index, [10:3] hex_value
  output      logic [1:0]          m_axis_tuser,   // [1:0] token_kind
  output      logic                m_axis_tlast    // line_end
);

  ctc_entry_t push_entry, head_entry;
  logic       push, pop, full, empty;
  kind_e      out_kind;
  logic [2:0] out_idx;
  logic [7:0] out_hex;

  assign s_axis_tready = !full;

  ctc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .q_ready_i  (!full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ctc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (head_entry),
    .full_o      (full),
    .empty_o     (empty)
  );

  ctc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_idx_o   (out_idx),
    .out_hex_o   (out_hex),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {5'd0, out_hex, out_idx};

  a_last_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_EOL)))
    else $error("tlast and end-of-line kind disagree");

  a_idx_only_kw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_KEYWORD) |-> (m_axis_tdata[2:0] == 3'd0))
    else $error("keyword index set on non-keyword word");

  a_hex_only_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_HEX) |-> (m_axis_tdata[10:3] == 8'd0))
    else $error("hex value set on non-hex word");

  a_eol_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'd0) |=> !empty)
    else $error("end of line lost");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command token classifier.
// A short table of command bytes covers the corner cases, then random
// command lines run under several keyword settings. Random stalls are applied
// on both streams. Every output word is checked against the pinned word of its
// table row or against a token predictor built into the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import ctc_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] idx;
    logic [7:0] hex;
    logic       last;
  } tok_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       pin;
    tok_res_t   res;
  } dir_row_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CASE_GAP     = 8'h20;
  localparam logic [2:0] REG_KW_FIRST = 3'd0;
  localparam int         LEN_SAT      = KEYWORD_CHARS + 1;
  localparam int         PHASES       = 7;
  localparam int         PHASE_ITEMS  = 262;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DIR_ROWS     = 27;

  localparam tok_res_t EOL_RES = '{kind: KIND_EOL, idx: 3'd0, hex: 8'h00, last: 1'b1};
  localparam tok_res_t NO_PIN  = '{kind: KIND_NONE, idx: 3'd0, hex: 8'h00, last: 1'b0};

  // pinned rows carry the word they must produce
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{CH_NUL,   1'b1, EOL_RES},
    '{CH_SPACE, 1'b0, NO_PIN},
    '{"L",      1'b0, NO_PIN},
    '{"e",      1'b0, NO_PIN},
    '{"D",      1'b0, NO_PIN},
    '{CH_SPACE, 1'b1, '{KIND_KEYWORD, 3'd1, 8'h00, 1'b0}},
    '{CH_SPACE, 1'b0, NO_PIN},
    '{"0",      1'b0, NO_PIN},
    '{"x",      1'b0, NO_PIN},
    '{"a",      1'b0, NO_PIN},
    '{"F",      1'b0, NO_PIN},
    '{CH_SPACE, 1'b1, '{KIND_HEX, 3'd0, 8'hAF, 1'b0}},
    '{"0",      1'b0, NO_PIN},
    '{"X",      1'b0, NO_PIN},
    '{"0",      1'b0, NO_PIN},
    '{"0",      1'b0, NO_PIN},
    '{CH_SPACE, 1'b1, '{KIND_NONE, 3'd0, 8'h00, 1'b0}},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'hFF,    1'b0, NO_PIN},
    '{8'h01,    1'b0, NO_PIN},
    '{CH_NUL,   1'b0, NO_PIN}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [KW_WIDTH-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  command_token_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [KW_WIDTH-1:0] kw_reg [MAX_KEYWORDS];
  logic [2:0]          kw_num;
  logic [7:0]          tok_buf [KEYWORD_CHARS];
  logic [3:0]          tok_len;
  logic                tok_open;

  tok_res_t   token_q [$];
  tok_res_t   want;
  logic [7:0] line_q [$];
  string      hex_chars = "0123456789abcdefABCDEF";

  logic     drv_pin;
  tok_res_t drv_res;
  int       err_cnt;
  int       snd_run;
  int       rcv_run;
  bit       snd_no_gap;
  int       recv_hold;

  function automatic int hex_nib(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic bit kw_hit(logic [KW_WIDTH-1:0] kw);
    int         klen;
    logic [7:0] t;
    klen = 0;
    while (klen < KEYWORD_CHARS && kw[8*klen +: 8] != CH_NUL) klen++;
    if (klen == 0 || int'(tok_len) != klen) return 1'b0;
    for (int i = 0; i < klen; i++) begin
      t = tok_buf[i];
      if (t >= "A" && t <= "Z") t = t + CASE_GAP;
      if (t != kw[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic tok_res_t judge_token();
    tok_res_t r;
    int       n;
    int       hi;
    int       lo;
    r = NO_PIN;
    n = (int'(kw_num) > MAX_KEYWORDS) ? MAX_KEYWORDS : int'(kw_num);
    for (int j = 0; j < n; j++) begin
      if (kw_hit(kw_reg[j])) begin
        r.kind = KIND_KEYWORD;
        r.idx  = 3'(j);
        return r;
      end
    end
    if (tok_len == 4'd4 && tok_buf[0] == "0" && tok_buf[1] == "x") begin
      hi = hex_nib(tok_buf[2]);
      lo = hex_nib(tok_buf[3]);
      if (hi >= 0 && lo >= 0) begin
        r.kind = KIND_HEX;
        r.hex  = {hi[3:0], lo[3:0]};
      end
    end
    return r;
  endfunction

  function void take_char(logic [7:0] c, bit keep);
    if (c == CH_NUL || c == CH_SPACE) begin
      if (tok_open && keep) token_q.push_back(judge_token());
      if (c == CH_NUL && keep) token_q.push_back(EOL_RES);
      for (int i = 0; i < KEYWORD_CHARS; i++) tok_buf[i] = CH_NUL;
      tok_len  = 4'd0;
      tok_open = 1'b0;
    end else begin
      if (tok_len < KEYWORD_CHARS) tok_buf[tok_len[2:0]] = c;
      if (tok_len < LEN_SAT) tok_len++;
      tok_open = 1'b1;
    end
  endfunction

  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [KW_WIDTH-1:0] rand_word(int len);
    logic [KW_WIDTH-1:0] w;
    w = '0;
    for (int i = 0; i < len; i++) w[8*i +: 8] = "a" + 8'($urandom_range(0, 25));
    return w;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [KW_WIDTH-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_KW_COUNT) kw_num = val[2:0];
    else kw_reg[idx - REG_KW_FIRST] = val;
  endtask

  task automatic send_byte(logic [7:0] c, logic pin, tok_res_t res);
    int gap;
    gap = snd_no_gap ? 0 : draw_wait(snd_run);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    drv_pin       = pin;
    drv_res       = res;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (token_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // one command line: mostly well-formed tokens, sometimes raw noise
  task automatic build_line();
    int                  ntok;
    int                  sel;
    int                  n;
    logic [7:0]          c;
    logic [KW_WIDTH-1:0] w;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_NUL);
      return;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
    ntok = $urandom_range(0, 4);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 3)) line_q.push_back(CH_SPACE);
      sel = $urandom_range(0, 7);
      if (sel < 4) begin
        w = kw_reg[$urandom_range(0, MAX_KEYWORDS - 1)];
        n = 0;
        while (n < KEYWORD_CHARS && w[8*n +: 8] != CH_NUL) begin
          c = w[8*n +: 8];
          if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - CASE_GAP;
          line_q.push_back(c);
          n++;
        end
        if (n > 0 && $urandom_range(0, 5) == 0) void'(line_q.pop_back());
        else if ($urandom_range(0, 5) == 0) line_q.push_back("a" + 8'($urandom_range(0, 25)));
      end else if (sel < 6) begin
        line_q.push_back("0");
        line_q.push_back(($urandom_range(0, 5) == 0) ? "X" : "x");
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 2;
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(33, 126));
          else c = hex_chars[$urandom_range(0, 21)];
          line_q.push_back(c);
        end
      end else if (sel == 6) begin
        n = $urandom_range(1, 11);
        repeat (n) begin
          c = 8'($urandom_range(1, 254));
          if (c == CH_SPACE) c = 8'hFF;
          line_q.push_back(c);
        end
      end else begin
        repeat ($urandom_range(7, 10)) line_q.push_back(8'hFF);
      end
    end
    if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
    line_q.push_back(CH_NUL);
  endtask

  // expected words are queued on input acceptance, checked on output acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_q.size() == 0) begin
          $error("unexpected word: token_kind %0d", m_axis_tuser);
          err_cnt++;
        end else begin
          want = token_q.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[2:0] !== want.idx) begin
            $error("keyword_index: expected %0d, got %0d", want.idx, m_axis_tdata[2:0]);
            err_cnt++;
          end
          if (m_axis_tdata[10:3] !== want.hex) begin
            $error("hex_value: expected %0d, got %0d", want.hex, m_axis_tdata[10:3]);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("line_end: expected %0d, got %0d", want.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_char(s_axis_tdata, !drv_pin);
        if (drv_pin) token_q.push_back(drv_res);
      end
    end
  end

  // output side stalls; a requested hold-off keeps tready low for a long stretch
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        m_axis_tready = 1'b0;
        repeat (recv_hold) @(negedge clk_i);
        recv_hold = 0;
      end
      gap = draw_wait(rcv_run);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                  sent;
    bit                  paused;
    logic [KW_WIDTH-1:0] w;
    logic [2:0]          cnt;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KW_FIRST;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = CH_NUL;
    drv_pin       = 1'b0;
    drv_res       = NO_PIN;
    err_cnt       = 0;
    snd_run       = 0;
    rcv_run       = 0;
    snd_no_gap    = 1'b0;
    recv_hold     = 0;
    for (int j = 0; j < MAX_KEYWORDS; j++) kw_reg[j] = '0;
    kw_num = 3'd0;
    take_char(CH_SPACE, 1'b0);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // help, led, all ones, empty, uppercase, embedded zero; count above max
    write_reg(REG_KW_FIRST + 3'd0, 64'h0000_0000_706c_6568);
    write_reg(REG_KW_FIRST + 3'd1, 64'h0000_0000_0064_656c);
    write_reg(REG_KW_FIRST + 3'd2, '1);
    write_reg(REG_KW_FIRST + 3'd3, '0);
    write_reg(REG_KW_FIRST + 3'd4, 64'h0000_0000_0000_7055);
    write_reg(REG_KW_FIRST + 3'd5, 64'h0000_0064_6300_6261);
    write_reg(REG_KW_COUNT, 64'd7);
    for (int i = 0; i < DIR_ROWS; i++) send_byte(DIR_TAB[i].ch, DIR_TAB[i].pin, DIR_TAB[i].res);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      for (int j = 0; j < MAX_KEYWORDS; j++) begin
        case (p)
          2: begin
            case (j)
              0: w = '1;
              1: w = '0;
              2: begin
                w = rand_word(3);
                w[7:0] = w[7:0] - CASE_GAP;
              end
              3: begin
                w = rand_word(5);
                w[23:16] = CH_NUL;
              end
              default: w = rand_word($urandom_range(1, KEYWORD_CHARS));
            endcase
          end
          3: w = {$urandom, $urandom};
          5: w = rand_word(KEYWORD_CHARS);
          6: w = rand_word(1);
          default: w = rand_word($urandom_range(1, KEYWORD_CHARS));
        endcase
        write_reg(REG_KW_FIRST + 3'(j), w);
      end
      case (p)
        0: cnt = 3'd0;
        1, 5: cnt = 3'd6;
        2: cnt = 3'd7;
        3: cnt = 3'($urandom_range(0, 7));
        4: cnt = 3'd3;
        default: cnt = 3'd5;
      endcase
      write_reg(REG_KW_COUNT, 64'(cnt));

      if (p == 4) begin
        snd_no_gap = 1'b1;
        recv_hold  = HOLD_CYCLES;
      end
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_line();
        foreach (line_q[i]) begin
          send_byte(line_q[i], 1'b0, NO_PIN);
          sent++;
        end
        if (snd_no_gap && sent >= 120) snd_no_gap = 1'b0;
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          s_axis_tvalid = 1'b0;
          while (token_q.size() != 0) @(negedge clk_i);
          paused = 1'b1;
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/ctc_pkg.sv
rtl/ctc_front.sv
rtl/ctc_fifo.sv
rtl/ctc_back.sv
rtl/command_token_classifier.sv
tb/tb_top.sv
